@@ rtl/core/serial_command_deframer_crc16_core_assert.svh @@
// Assertion macros for the serial command deframer core.
// Used by serial_command_deframer_crc16_core; expects clk_i and rst_ni in scope.
`ifndef SERIAL_COMMAND_DEFRAMER_CRC16_CORE_ASSERT_SVH
`define SERIAL_COMMAND_DEFRAMER_CRC16_CORE_ASSERT_SVH

// same-cycle implication
`define SCD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SCD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/scdc16_pkg.sv @@
// Package for the serial command deframer: state and status codes,
// register indexes and the CRC-16/Modbus byte update. No dependencies.
package scdc16_pkg;

  typedef enum logic [1:0] {
    S_RX,
    S_CRC,
    S_EMIT,
    S_SINGLE
  } state_e;

  typedef enum logic [1:0] {
    ST_CMD,
    ST_CRC_ERR,
    ST_SHORT,
    ST_EMPTY
  } status_e;

  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CFG_IDX_HEAD = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_IDX_TAIL = 2'd1;

  localparam logic [7:0]  HEAD_RESET = 8'hEE;
  localparam logic [31:0] TAIL_RESET = 32'hFFFC_FFFF;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // head + two CRC bytes + four tail bytes
  localparam int unsigned MIN_FRAME_BYTES = 7;

  function automatic logic [15:0] crc16_feed(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

@@ rtl/core/serial_command_deframer_crc16_core.sv @@
// Serial command deframer with CRC-16/Modbus check, top level.
// Depends on scdc16_pkg and serial_command_deframer_crc16_core_assert.svh.
//
//  channel | ports                          | dir | payload
//  rx      | s_axis_tvalid/tready/tdata     | in  | tdata[7:0] rx_byte
//  result  | m_axis_tvalid/tready/tdata/... | out | tdata data_byte, tuser status, tlast
//  config  | cfg_valid_i/ready_o/index/data | in  | index 0 head_byte, 1 tail_word
//
// Received frame bytes are written into the frame memory. At frame end the input
// stalls: a CRC sweep runs over the command bytes through the memory read
// port. Emission first reads the first command byte, then delivers one beat
// per cycle while the output is ready; otherwise a single status beat goes
// out. Output stalls hold the pipe.
// Reset clears counters and window; the frame memory needs no clearing pass.
module serial_command_deframer_crc16_core
  import scdc16_pkg::*;
#(
  parameter int unsigned BUFFER_BYTES = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [7:0]         s_axis_tdata,   // [7:0] rx_byte
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [7:0]         m_axis_tdata,   // [7:0] data_byte
  output logic [1:0]         m_axis_tuser,   // [1:0] status
  output logic               m_axis_tlast,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [31:0]        cfg_data_i
);

  localparam int unsigned CW = $clog2(BUFFER_BYTES + 1);
  localparam int unsigned AW = $clog2(BUFFER_BYTES);

  state_e          state_q, state_d;
  logic [CW-1:0]   count_q, count_d;
  logic [31:0]     win_q, win_d;
  logic            ovf_q, ovf_d;
  logic [CW-1:0]   len_q, len_d;
  logic [CW-1:0]   iss_q, iss_d;
  logic [CW-1:0]   con_q, con_d;
  logic            pend_q, pend_d;
  logic [15:0]     crc_q, crc_d;
  logic [15:0]     hist_q, hist_d;
  status_e         sst_q, sst_d;
  logic [7:0]      head_q;
  logic [31:0]     tail_q;

  logic            ov_q;
  status_e         ost_q;
  logic [7:0]      odat_q;
  logic            olast_q;

  logic [7:0]      mem_q [BUFFER_BYTES];
  logic            mem_we, mem_re;
  logic [AW-1:0]   mem_waddr, mem_raddr;
  logic [7:0]      mem_rdata_q;

  logic            in_acc, skip, room, frame_end, is_short, out_free;
  logic [31:0]     win_nx;
  logic [CW-1:0]   cnt_nx;
  logic            ovf_nx, crc_done, issue;
  logic            o_load, o_last;
  status_e         o_st;
  logic [7:0]      o_dat;

  assign s_axis_tready = (state_q == S_RX);
  assign cfg_ready_o   = 1'b1;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !ov_q || m_axis_tready;

  assign skip      = (count_q == '0) && !ovf_q && (s_axis_tdata != head_q);
  assign room      = count_q < CW'(BUFFER_BYTES);
  assign win_nx    = {win_q[23:0], s_axis_tdata};
  assign cnt_nx    = room ? count_q + CW'(1) : count_q;
  assign ovf_nx    = ovf_q || !room;
  assign frame_end = in_acc && !skip && (win_nx == tail_q);
  assign is_short  = ovf_nx || (cnt_nx < CW'(MIN_FRAME_BYTES));
  assign crc_done  = (con_q == len_q);
  assign issue     = (iss_q < len_q) && ((state_q == S_CRC) || !pend_q || o_load);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_RX: begin
        if (frame_end) begin
          state_d = is_short ? S_SINGLE : S_CRC;
        end
      end
      S_CRC: begin
        if (crc_done) begin
          state_d = ((crc_q != hist_q) || (len_q == '0)) ? S_SINGLE : S_EMIT;
        end
      end
      S_EMIT: begin
        if (o_load && o_last) begin
          state_d = S_RX;
        end
      end
      S_SINGLE: begin
        if (out_free) begin
          state_d = S_RX;
        end
      end
      default: state_d = S_RX;
    endcase
  end

  // datapath and outputs
  always_comb begin
    count_d   = count_q;
    win_d     = win_q;
    ovf_d     = ovf_q;
    len_d     = len_q;
    iss_d     = iss_q;
    con_d     = con_q;
    pend_d    = pend_q;
    crc_d     = crc_q;
    hist_d    = hist_q;
    sst_d     = sst_q;
    mem_we    = 1'b0;
    mem_waddr = count_q[AW-1:0];
    mem_re    = 1'b0;
    mem_raddr = AW'(iss_q + CW'(1));
    o_load    = 1'b0;
    o_st      = ST_CMD;
    o_dat     = 8'h00;
    o_last    = 1'b1;
    unique case (state_q)
      S_RX: begin
        if (in_acc && !skip) begin
          mem_we = room;
          hist_d = {hist_q[7:0], win_q[31:24]};
          if (frame_end) begin
            count_d = '0;
            win_d   = '0;
            ovf_d   = 1'b0;
            len_d   = cnt_nx - CW'(MIN_FRAME_BYTES);
            iss_d   = '0;
            con_d   = '0;
            pend_d  = 1'b0;
            crc_d   = CRC_INIT;
            sst_d   = ST_SHORT;
          end else begin
            count_d = cnt_nx;
            win_d   = win_nx;
            ovf_d   = ovf_nx;
          end
        end
      end
      S_CRC: begin
        mem_re = issue;
        iss_d  = issue ? iss_q + CW'(1) : iss_q;
        pend_d = issue;
        if (pend_q) begin
          crc_d = crc16_feed(crc_q, mem_rdata_q);
          con_d = con_q + CW'(1);
        end
        if (crc_done) begin
          sst_d  = (crc_q != hist_q) ? ST_CRC_ERR : ST_EMPTY;
          iss_d  = '0;
          con_d  = '0;
          pend_d = 1'b0;
        end
      end
      S_EMIT: begin
        o_load = pend_q && out_free;
        o_dat  = mem_rdata_q;
        o_last = (con_q + CW'(1) == len_q);
        mem_re = issue;
        iss_d  = issue ? iss_q + CW'(1) : iss_q;
        con_d  = o_load ? con_q + CW'(1) : con_q;
        pend_d = (pend_q && !o_load) || issue;
      end
      S_SINGLE: begin
        o_load = out_free;
        o_st   = sst_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= s_axis_tdata;
    end
    if (mem_re) begin
      mem_rdata_q <= mem_q[mem_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_RX;
      count_q <= '0;
      win_q   <= '0;
      ovf_q   <= 1'b0;
      len_q   <= '0;
      iss_q   <= '0;
      con_q   <= '0;
      pend_q  <= 1'b0;
      ov_q    <= 1'b0;
      head_q  <= HEAD_RESET;
      tail_q  <= TAIL_RESET;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      win_q   <= win_d;
      ovf_q   <= ovf_d;
      len_q   <= len_d;
      iss_q   <= iss_d;
      con_q   <= con_d;
      pend_q  <= pend_d;
      if (o_load) begin
        ov_q <= 1'b1;
      end else if (m_axis_tready) begin
        ov_q <= 1'b0;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          CFG_IDX_HEAD: head_q <= cfg_data_i[7:0];
          CFG_IDX_TAIL: tail_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    crc_q  <= crc_d;
    hist_q <= hist_d;
    sst_q  <= sst_d;
    if (o_load) begin
      ost_q   <= o_st;
      odat_q  <= o_dat;
      olast_q <= o_last;
    end
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = odat_q;
  assign m_axis_tuser  = ost_q;
  assign m_axis_tlast  = olast_q;

`include "serial_command_deframer_crc16_core_assert.svh"

  `SCD_ASSERT_NOW(a_con_le_iss, 1'b1, con_q <= iss_q, "consumed reads exceed issued reads")
  `SCD_ASSERT_NOW(a_emit_pend, (state_q == S_EMIT) && pend_q, iss_q == con_q + CW'(1), "emit read pipeline out of step")
  `SCD_ASSERT_NEXT(a_frame_clr, frame_end, (count_q == '0) && (win_q == '0) && !ovf_q, "frame end did not clear state")

endmodule

@@ tb/sv/scdc16_frame_checker.sv @@
// Frame checker for serial_command_deframer_crc16_core: tracks config writes and rx beats,
// rebuilds each frame, predicts the result beats and compares them in order.
// Depends on scdc16_pkg for status codes, register indexes and reset values.
module scdc16_frame_checker
  import scdc16_pkg::*;
#(
  parameter int unsigned BUFFER_BYTES = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               rx_valid_i,
  input  logic               rx_ready_i,
  input  logic [7:0]         rx_data_i,
  input  logic               res_valid_i,
  input  logic               res_ready_i,
  input  logic [7:0]         res_data_i,
  input  logic [1:0]         res_user_i,
  input  logic               res_last_i,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  output int unsigned        errors_o,
  output int unsigned        pending_o,
  output logic               frame_open_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    status_e    status;
    logic [7:0] data;
    logic       last;
  } result_t;

  logic [7:0]  head_q;
  logic [31:0] tail_q;
  logic [7:0]  frame_mem [BUFFER_BYTES];
  int unsigned fill;
  logic [31:0] window;
  logic        overflow;
  int unsigned mismatches;
  result_t     expected_q [$];

  // bit-serial reflected CRC over the command bytes (frame_mem[1..len])
  function automatic logic [15:0] command_crc(input int unsigned len);
    logic [15:0] acc;
    logic        fb;
    acc = CRC_INIT;
    for (int unsigned i = 0; i < len; i++) begin
      for (int j = 0; j < 8; j++) begin
        fb  = acc[0] ^ frame_mem[1 + i][j];
        acc = acc >> 1;
        if (fb) begin
          acc = acc ^ CRC_POLY;
        end
      end
    end
    return acc;
  endfunction

  task automatic deframe_byte(input logic [7:0] b_in);
    int unsigned n;
    int unsigned cmd_len;
    logic        was_over;
    logic [15:0] stored;
    if (fill == 0 && !overflow && b_in != head_q) begin
      return;
    end
    if (fill < BUFFER_BYTES) begin
      frame_mem[fill] = b_in;
      fill++;
    end else begin
      overflow = 1'b1;
    end
    window = {window[23:0], b_in};
    if (window != tail_q) begin
      return;
    end
    n        = fill;
    was_over = overflow;
    fill     = 0;
    window   = '0;
    overflow = 1'b0;
    if (was_over || n < MIN_FRAME_BYTES) begin
      expected_q.push_back(result_t'{ST_SHORT, 8'h00, 1'b1});
      return;
    end
    cmd_len = n - MIN_FRAME_BYTES;
    stored  = {frame_mem[1 + cmd_len], frame_mem[2 + cmd_len]};
    if (command_crc(cmd_len) != stored) begin
      expected_q.push_back(result_t'{ST_CRC_ERR, 8'h00, 1'b1});
    end else if (cmd_len == 0) begin
      expected_q.push_back(result_t'{ST_EMPTY, 8'h00, 1'b1});
    end else begin
      for (int unsigned i = 0; i < cmd_len; i++) begin
        expected_q.push_back(result_t'{ST_CMD, frame_mem[1 + i], logic'(i + 1 == cmd_len)});
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    if (!rst_ni) begin
      head_q     = HEAD_RESET;
      tail_q     = TAIL_RESET;
      fill       = 0;
      window     = '0;
      overflow   = 1'b0;
      mismatches = 0;
      expected_q.delete();
    end else begin
      if (res_valid_i && res_ready_i) begin
        if (expected_q.size() == 0) begin
          mismatches++;
          $error("unexpected result beat: status %0d data_byte 0x%02h last_flag %0b",
                 res_user_i, res_data_i, res_last_i);
        end else begin
          want = expected_q.pop_front();
          if (res_user_i !== want.status) begin
            mismatches++;
            $error("status: expected %0d, got %0d", want.status, res_user_i);
          end
          if (res_data_i !== want.data) begin
            mismatches++;
            $error("data_byte: expected 0x%02h, got 0x%02h", want.data, res_data_i);
          end
          if (res_last_i !== want.last) begin
            mismatches++;
            $error("last_flag: expected %0b, got %0b", want.last, res_last_i);
          end
        end
      end
      if (rx_valid_i && rx_ready_i) begin
        deframe_byte(rx_data_i);
      end
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == CFG_IDX_HEAD) begin
          head_q = cfg_data_i[7:0];
        end else if (cfg_index_i == CFG_IDX_TAIL) begin
          tail_q = cfg_data_i;
        end
      end
    end
    errors_o     <= mismatches;
    pending_o    <= expected_q.size();
    frame_open_o <= (fill != 0) || overflow;
  end

endmodule

@@ tb/sv/tb_serial_command_deframer_crc16_core.sv @@
// Testbench top for serial_command_deframer_crc16_core: drives directed and random frames
// across several head/tail settings with random gaps and stalls, and gives the verdict.
// Depends on scdc16_pkg, the core RTL and scdc16_frame_checker.
module tb_serial_command_deframer_crc16_core
  import scdc16_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned BufferBytes  = 64;
  localparam int unsigned MaxCmdBytes  = BufferBytes - MIN_FRAME_BYTES;
  localparam int unsigned CycleLimit   = 5000000;
  localparam int unsigned SettleCycles = 16;
  localparam logic [CfgIdxW-1:0] CFG_IDX_SPARE_LO = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_IDX_SPARE_HI = 2'd3;

  typedef logic [7:0] octet_q_t [$];

  logic               clk_i;
  logic               rst_ni;
  logic               s_axis_tvalid;
  logic               s_axis_tready;
  logic [7:0]         s_axis_tdata;
  logic               m_axis_tvalid;
  logic               m_axis_tready;
  logic [7:0]         m_axis_tdata;
  logic [1:0]         m_axis_tuser;
  logic               m_axis_tlast;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i;
  logic [31:0]        cfg_data_i;

  int unsigned err_count;
  int unsigned pending_beats;
  logic        frame_open;

  logic [7:0]  head_cfg;
  logic [31:0] tail_cfg;
  bit          in_gaps;
  bit          out_stalls;
  int unsigned frame_bytes;

  serial_command_deframer_crc16_core #(
    .BUFFER_BYTES(BufferBytes)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  scdc16_frame_checker #(
    .BUFFER_BYTES(BufferBytes)
  ) u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rx_valid_i  (s_axis_tvalid),
    .rx_ready_i  (s_axis_tready),
    .rx_data_i   (s_axis_tdata),
    .res_valid_i (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_data_i  (m_axis_tdata),
    .res_user_i  (m_axis_tuser),
    .res_last_i  (m_axis_tlast),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_i (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .errors_o    (err_count),
    .pending_o   (pending_beats),
    .frame_open_o(frame_open)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    repeat (CycleLimit) @(posedge clk_i);
    $display("tb_serial_command_deframer_crc16_core: done, errors");
    $finish;
  end

  function automatic int unsigned pick_gap(input bit enabled);
    int unsigned r;
    if (!enabled) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end
    if (r < 88) begin
      return $urandom_range(1, 3);
    end
    if (r < 97) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 60);
  endfunction

  // result side backpressure
  initial begin
    int unsigned hold;
    hold          = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (!out_stalls) begin
        m_axis_tready = 1'b1;
      end else if (hold != 0) begin
        m_axis_tready = 1'b0;
        hold--;
      end else if ($urandom_range(0, 99) < 65) begin
        m_axis_tready = 1'b1;
      end else begin
        m_axis_tready = 1'b0;
        hold          = pick_gap(1'b1);
      end
    end
  end

  // called at a falling edge, returns at the falling edge after the beat
  task automatic send_byte(input logic [7:0] value);
    int unsigned gap;
    gap = pick_gap(in_gaps);
    if (gap != 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = value;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  function automatic octet_q_t random_cmd(input int unsigned len);
    octet_q_t q;
    repeat (len) q.push_back(8'($urandom));
    return q;
  endfunction

  function automatic int unsigned pick_cmd_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      return $urandom_range(0, 8);
    end
    if (r < 95) begin
      return $urandom_range(9, 40);
    end
    return $urandom_range(41, MaxCmdBytes);
  endfunction

  task automatic send_frame(input octet_q_t cmd, input bit bad_crc);
    logic [15:0] crc;
    int unsigned flip;
    crc = CRC_INIT;
    foreach (cmd[i]) crc = crc16_feed(crc, cmd[i]);
    if (bad_crc) begin
      flip      = $urandom_range(0, 15);
      crc[flip] = ~crc[flip];
    end
    send_byte(head_cfg);
    foreach (cmd[i]) send_byte(cmd[i]);
    send_byte(crc[15:8]);
    send_byte(crc[7:0]);
    for (int k = 3; k >= 0; k--) begin
      send_byte(tail_cfg[8*k +: 8]);
    end
    frame_bytes += cmd.size() + MIN_FRAME_BYTES;
  endtask

  // head, extra random bytes, then the tail: too short to carry a CRC when extra is 0 or 1
  task automatic send_short(input int unsigned extra);
    send_byte(head_cfg);
    repeat (extra) send_byte(8'($urandom));
    for (int k = 3; k >= 0; k--) begin
      send_byte(tail_cfg[8*k +: 8]);
    end
    frame_bytes += extra + 5;
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [31:0] value);
    cfg_index_i = idx;
    cfg_data_i  = value;
    cfg_valid_i = 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
    if (idx == CFG_IDX_HEAD) begin
      head_cfg = value[7:0];
    end else if (idx == CFG_IDX_TAIL) begin
      tail_cfg = value;
    end
  endtask

  // finish any open frame with tail bytes, then wait for all results
  task automatic close_and_settle();
    int unsigned k;
    k = 0;
    while (frame_open) begin
      send_byte(tail_cfg[8*(3 - k % 4) +: 8]);
      k++;
    end
    s_axis_tvalid = 1'b0;
    while (pending_beats != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic random_phase(input int unsigned min_bytes);
    int unsigned start;
    int unsigned r;
    int unsigned len;
    start = frame_bytes;
    while (frame_bytes - start < min_bytes) begin
      r = $urandom_range(0, 99);
      if (r < 66) begin
        send_frame(random_cmd(pick_cmd_len()), 1'b0);
      end else if (r < 76) begin
        send_frame(random_cmd(pick_cmd_len()), 1'b1);
      end else if (r < 80) begin
        send_frame(random_cmd($urandom_range(MaxCmdBytes + 1, MaxCmdBytes + 5)), 1'b0);
      end else if (r < 84) begin
        send_short($urandom_range(0, 1));
      end else if (r < 91) begin
        repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
      end else if (r < 96) begin
        // truncated frame, the next frame's bytes land in it
        len = $urandom_range(0, 10);
        send_byte(head_cfg);
        repeat (len) send_byte(8'($urandom));
        frame_bytes += len + 1;
      end else begin
        s_axis_tvalid = 1'b0;
        while (pending_beats != 0) @(negedge clk_i);
      end
    end
  endtask

  task automatic config_phase(input logic [7:0] head, input logic [31:0] tail,
                              input bit gaps, input bit stalls, input int unsigned min_bytes);
    close_and_settle();
    write_reg(CFG_IDX_HEAD, {24'h0, head});
    write_reg(CFG_IDX_TAIL, tail);
    in_gaps    = gaps;
    out_stalls = stalls;
    random_phase(min_bytes);
  endtask

  initial begin
    octet_q_t none;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = CFG_IDX_HEAD;
    cfg_data_i    = '0;
    head_cfg      = HEAD_RESET;
    tail_cfg      = TAIL_RESET;
    in_gaps       = 1'b1;
    out_stalls    = 1'b1;
    frame_bytes   = 0;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // idle bytes that are not the head
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h55);
    send_frame(none, 1'b0);
    send_frame('{8'h00}, 1'b0);
    send_frame('{8'hFF, 8'h00, 8'hA5, 8'h5A}, 1'b0);
    send_frame('{8'h7F}, 1'b1);
    send_short(0);
    send_short(1);
    send_frame(random_cmd(MaxCmdBytes), 1'b0);
    send_frame(random_cmd(MaxCmdBytes + 1), 1'b0);

    // writes to indexes past the register list must be dropped
    close_and_settle();
    write_reg(CFG_IDX_SPARE_LO, $urandom);
    write_reg(CFG_IDX_SPARE_HI, $urandom);

    config_phase(HEAD_RESET, TAIL_RESET, 1'b1, 1'b1, 16);
    config_phase(8'h00, 32'h0000_0000, 1'b0, 1'b0, 8);
    config_phase(8'hFF, 32'hFFFF_FFFF, 1'b1, 1'b0, 8);
    config_phase(8'($urandom), $urandom, 1'b0, 1'b1, 8);
    config_phase(8'($urandom), $urandom, 1'b1, 1'b1, 8);
    config_phase(HEAD_RESET, TAIL_RESET, 1'b1, 1'b1, 16);
    close_and_settle();

    if (err_count == 0) begin
      $display("tb_serial_command_deframer_crc16_core: done, clean");
    end else begin
      $display("tb_serial_command_deframer_crc16_core: done, errors");
    end
    $finish;
  end

endmodule

@@ serial_command_deframer_crc16_core.f @@
+incdir+rtl/core
rtl/core/scdc16_pkg.sv
rtl/core/serial_command_deframer_crc16_core.sv
tb/sv/scdc16_frame_checker.sv
tb/sv/tb_serial_command_deframer_crc16_core.sv
